// ===== src/rbpp_pkg.sv =====
package rbpp_pkg;

  // Panel geometry defaults
  localparam int DEF_PANEL_WIDTH  = 176;
  localparam int DEF_PANEL_HEIGHT = 264;

  // Payload widths
  localparam int COORD_W    = 16;
  localparam int COLOR_W    = 3;
  localparam int BYTE_ADDR_W = 13;
  localparam int STATUS_W   = 2;
  localparam int DATA_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Item kinds
  localparam logic KIND_PLOT = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Plane select for reads
  localparam logic PLANE_BLACK = 1'b0;
  localparam logic PLANE_COLOR = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OFF       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_COLOR = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_OFS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLACK_INV = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_INV = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_ON  = 3'd4;

  // Colour indexes
  localparam logic [COLOR_W-1:0] COL_WHITE = 3'd0;
  localparam logic [COLOR_W-1:0] COL_BLACK = 3'd1;
  localparam logic [COLOR_W-1:0] COL_RED   = 3'd2;
  localparam logic [COLOR_W-1:0] COL_GRAY  = 3'd3;
  localparam logic [COLOR_W-1:0] COL_DARK  = 3'd4;
  localparam logic [COLOR_W-1:0] COL_LIGHT = 3'd5;

  // Plane bit pairs: bit 1 colour plane, bit 0 black plane
  localparam logic [1:0] BITS_NONE  = 2'b00;
  localparam logic [1:0] BITS_BLACK = 2'b01;
  localparam logic [1:0] BITS_COLOR = 2'b10;

  typedef logic [1:0] plane_bits_t;

  function automatic plane_bits_t plane_bits(input logic [COLOR_W-1:0] color);
    plane_bits_t b;
    b = BITS_NONE;
    case (color)
      COL_BLACK, COL_DARK: b = BITS_BLACK;
      COL_RED, COL_GRAY:   b = BITS_COLOR;
      default:             b = BITS_NONE;
    endcase
    return b;
  endfunction

  function automatic logic color_valid(input logic [COLOR_W-1:0] color);
    return (color <= COL_LIGHT);
  endfunction

endpackage

// ===== src/rbpp_if.sv =====
interface rbpp_in_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [rbpp_pkg::COORD_W-1:0]     x;
  logic [rbpp_pkg::COORD_W-1:0]     y;
  logic [rbpp_pkg::COLOR_W-1:0]     color;
  logic [rbpp_pkg::BYTE_ADDR_W-1:0] byte_addr;
  logic                             plane;
  logic                             invert;

  modport source (output valid, kind, x, y, color, byte_addr, plane, invert, input ready);
  modport sink   (input valid, kind, x, y, color, byte_addr, plane, invert, output ready);
endinterface

interface rbpp_out_if;
  logic                          valid;
  logic                          ready;
  logic [rbpp_pkg::STATUS_W-1:0] status;
  logic [rbpp_pkg::DATA_W-1:0]   read_data;

  modport source (output valid, status, read_data, input ready);
  modport sink   (input valid, status, read_data, output ready);
endinterface

interface rbpp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rbpp_pkg::CFG_IDX_W-1:0]  index;
  logic [rbpp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/rbpp_ram.sv =====
module rbpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // Hold read data until the next read
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/rotated_bitplane_pixel_plotter.sv =====
// Rotated bit-plane pixel plotter. Each input beat either plots one pixel into
// the two-plane frame store (black plane and colour plane, one bit per pixel,
// column-major bytes) or reads back one stored byte; every input beat yields
// exactly one result beat with a status and, for reads, the byte. Capture and
// rotation happen at the accepting edge; the result register loads once the item
// has passed the multiply, address and memory read, and modify and write-back
// states (modify waits for a free output register). The next item is taken in
// the cycle after the previous one has written back: each makes a single
// read-modify-write pass through the plane memories. A finished result waits in
// the output register without holding up the next input. After reset the block
// zeroes both planes' PANEL_WIDTH*PANEL_HEIGHT/8 bytes (5808 at the default
// panel size), one byte per cycle, taking no input beat meanwhile. Configuration
// writes are taken at any time but must only be issued while the block is idle.
module rotated_bitplane_pixel_plotter #(
  parameter int PANEL_WIDTH  = rbpp_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = rbpp_pkg::DEF_PANEL_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  rbpp_in_if.sink    in_ch,
  rbpp_out_if.source out_ch,
  rbpp_cfg_if.sink   cfg_ch
);

  // Geometry derived from the panel size
  localparam int STORE_DEPTH = (PANEL_WIDTH * PANEL_HEIGHT) / 8;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int MAX_SIDE    = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
  // Coordinate width: covers either side plus the largest row offset
  localparam int CW          = $clog2(MAX_SIDE + 16);
  // Width of the pre-divide bit index
  localparam int SUMW        = $clog2(PANEL_WIDTH * PANEL_HEIGHT + 16);
  localparam int LW          = (SUMW > rbpp_pkg::BYTE_ADDR_W) ? SUMW : rbpp_pkg::BYTE_ADDR_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_ADDR = 2'd2;
  localparam logic [1:0] S_MOD  = 2'd3;

  localparam int DW = rbpp_pkg::DATA_W;

  // Configuration registers
  logic [1:0] rotation_r;
  logic [3:0] row_ofs_r;
  logic       black_inv_r;
  logic       color_inv_r;
  logic       color_on_r;

  // Control
  logic [1:0]    state_r, state_nxt;
  logic          clearing_r;
  logic [AW-1:0] clr_cnt_r;

  // Item in flight
  logic                                  kind_r;
  logic                                  plane_r;
  logic                                  invert_r;
  rbpp_pkg::plane_bits_t                 bits_r;
  logic [rbpp_pkg::STATUS_W-1:0]         status_r, status_nxt;
  logic [rbpp_pkg::BYTE_ADDR_W-1:0]      byte_addr_r;
  logic [CW-1:0]                         cterm_r;
  logic [CW-1:0]                         ry_r;
  logic [SUMW-1:0]                       prod_r;
  logic [AW-1:0]                         addr_r;
  logic [2:0]                            bitsel_r;

  // Output register
  logic                          out_valid_r;
  logic [rbpp_pkg::STATUS_W-1:0] out_status_r;
  logic [DW-1:0]                 out_data_r;

  // Front-end combinational terms
  logic                          in_fire;
  logic [CW-1:0]                 xl, yl, rx, ry;
  logic [rbpp_pkg::COORD_W-1:0]  lw, lh;
  logic                          off_screen;
  logic [rbpp_pkg::STATUS_W-1:0] plot_status;

  // Address stage
  logic [SUMW-1:0] bit_index;
  logic [LW-1:0]   addr_wide;
  logic            addr_bad;

  // Modify stage
  logic          out_free;
  logic          mod_fire;
  logic          item_ok;
  logic [DW-1:0] bit_mask;
  logic [DW-1:0] black_rdata, color_rdata;
  logic [DW-1:0] black_new, color_new;
  logic [DW-1:0] rd_byte;

  // Memory ports
  logic          ram_re;
  logic          black_we, color_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] black_wdata, color_wdata;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE) && !clearing_r;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // Register writes; values are masked to each register's width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_r  <= 2'd2;
      row_ofs_r   <= 4'd8;
      black_inv_r <= 1'b0;
      color_inv_r <= 1'b0;
      color_on_r  <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        rbpp_pkg::REG_ROTATION:  rotation_r  <= cfg_ch.data[1:0];
        rbpp_pkg::REG_ROW_OFS:   row_ofs_r   <= cfg_ch.data[3:0];
        rbpp_pkg::REG_BLACK_INV: black_inv_r <= cfg_ch.data[0];
        rbpp_pkg::REG_COLOR_INV: color_inv_r <= cfg_ch.data[0];
        rbpp_pkg::REG_COLOR_ON:  color_on_r  <= cfg_ch.data[0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Bounds check against the rotated logical size (quarter turns swap sides), then colour check
  always_comb begin
    lw = rotation_r[0] ? rbpp_pkg::COORD_W'(PANEL_HEIGHT) : rbpp_pkg::COORD_W'(PANEL_WIDTH);
    lh = rotation_r[0] ? rbpp_pkg::COORD_W'(PANEL_WIDTH) : rbpp_pkg::COORD_W'(PANEL_HEIGHT);
    off_screen = in_ch.x[rbpp_pkg::COORD_W-1] || in_ch.y[rbpp_pkg::COORD_W-1] ||
                 (in_ch.x >= lw) || (in_ch.y >= lh);
    if (off_screen) begin
      plot_status = rbpp_pkg::ST_OFF;
    end else if (!rbpp_pkg::color_valid(in_ch.color)) begin
      plot_status = rbpp_pkg::ST_BAD_COLOR;
    end else begin
      plot_status = rbpp_pkg::ST_OK;
    end
  end

  // Rotate. In range, x and y fit in CW bits; off-screen garbage is never used.
  always_comb begin
    xl = in_ch.x[CW-1:0];
    yl = in_ch.y[CW-1:0];
    unique case (rotation_r)
      2'd0: begin
        rx = xl;
        ry = yl + CW'(row_ofs_r);
      end
      2'd1: begin
        rx = CW'(PANEL_WIDTH - 1) - yl;
        ry = xl;
      end
      2'd2: begin
        rx = CW'(PANEL_WIDTH - 1) - xl;
        ry = CW'(PANEL_HEIGHT - 1) - yl + CW'(row_ofs_r);
      end
      default: begin
        rx = yl;
        ry = CW'(PANEL_HEIGHT - 1) - xl;
      end
    endcase
  end

  // Byte address: the rotated point in the column-major frame, or the given address for reads
  assign bit_index = prod_r + SUMW'(ry_r);
  always_comb begin
    if (kind_r == rbpp_pkg::KIND_READ) begin
      addr_wide = LW'(byte_addr_r);
    end else begin
      addr_wide = LW'(bit_index >> 3);
    end
    addr_bad = (addr_wide >= LW'(STORE_DEPTH));
  end

  always_comb begin
    status_nxt = status_r;
    if (status_r == rbpp_pkg::ST_OK && addr_bad) begin
      status_nxt = rbpp_pkg::ST_RANGE;
    end
  end

  // Sequencer: one item at a time, so reads never overlap a pending write
  assign out_free = !out_valid_r || out_ch.ready;
  assign mod_fire = (state_r == S_MOD) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ADDR;
      S_ADDR:  state_nxt = S_MOD;
      S_MOD:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item capture and datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r      <= in_ch.kind;
      plane_r     <= in_ch.plane;
      invert_r    <= in_ch.invert;
      byte_addr_r <= in_ch.byte_addr;
      bits_r      <= rbpp_pkg::plane_bits(in_ch.color);
      status_r    <= (in_ch.kind == rbpp_pkg::KIND_READ) ? rbpp_pkg::ST_OK : plot_status;
      cterm_r     <= CW'(PANEL_WIDTH - 1) - rx;
      ry_r        <= ry;
    end
    if (state_r == S_MUL) begin
      prod_r <= SUMW'(cterm_r) * SUMW'(PANEL_HEIGHT);
    end
    if (state_r == S_ADDR) begin
      status_r <= status_nxt;
      addr_r   <= addr_wide[AW-1:0];
      bitsel_r <= ~ry_r[2:0];
    end
  end

  // Issue the read for both planes; the byte arrives in S_MOD
  assign ram_re = (state_r == S_ADDR) && (status_nxt == rbpp_pkg::ST_OK);

  // Modify: set or clear the addressed bit in each plane
  assign item_ok  = (status_r == rbpp_pkg::ST_OK);
  assign bit_mask = DW'(1) << bitsel_r;
  assign black_new = (bits_r[0] ^ black_inv_r) ? (black_rdata | bit_mask)
                                                : (black_rdata & ~bit_mask);
  assign color_new = (bits_r[1] ^ color_inv_r) ? (color_rdata | bit_mask)
                                                : (color_rdata & ~bit_mask);
  assign rd_byte = ((plane_r == rbpp_pkg::PLANE_COLOR) ? color_rdata : black_rdata) ^
                   {DW{invert_r}};

  // Write port: the clearing sweep owns it until done
  always_comb begin
    if (clearing_r) begin
      black_we    = 1'b1;
      color_we    = 1'b1;
      ram_waddr   = clr_cnt_r;
      black_wdata = '0;
      color_wdata = '0;
    end else begin
      black_we    = mod_fire && item_ok && (kind_r == rbpp_pkg::KIND_PLOT);
      color_we    = black_we && color_on_r;
      ram_waddr   = addr_r;
      black_wdata = black_new;
      color_wdata = color_new;
    end
  end

  // Clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      if (clr_cnt_r == AW'(STORE_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // Output register: load on modify, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mod_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mod_fire) begin
      out_status_r <= status_r;
      out_data_r   <= (item_ok && kind_r == rbpp_pkg::KIND_READ) ? rd_byte : '0;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.read_data = out_data_r;

  rbpp_ram #(
    .WIDTH (DW),
    .DEPTH (STORE_DEPTH)
  ) u_black_ram (
    .clk   (clk),
    .we    (black_we),
    .waddr (ram_waddr),
    .wdata (black_wdata),
    .re    (ram_re),
    .raddr (addr_wide[AW-1:0]),
    .rdata (black_rdata)
  );

  rbpp_ram #(
    .WIDTH (DW),
    .DEPTH (STORE_DEPTH)
  ) u_color_ram (
    .clk   (clk),
    .we    (color_we),
    .waddr (ram_waddr),
    .wdata (color_wdata),
    .re    (ram_re),
    .raddr (addr_wide[AW-1:0]),
    .rdata (color_rdata)
  );

endmodule
